// ----- src/assert_macros.svh -----
// Assertion macros shared by the resampler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define LIR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle.
`define LIR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- src/lir_pkg.sv -----
// Types and constants of the linear-interpolation resampler.
`timescale 1ns / 1ps
package lir_pkg;

  localparam int SAMPLE_W = 16;
  localparam int PHASE_W  = 16;
  localparam int STEP_W   = 17;
  localparam int CHAN_W   = 2;
  localparam int CFG_W    = 17;
  localparam int CFG_IDX_W = 1;

  // 1.0 in unsigned Q16
  localparam logic [STEP_W-1:0] ONE_Q16 = 17'h10000;

  // reset values of the configuration registers
  localparam logic [STEP_W-1:0] STEP_RESET = 17'd60211;
  localparam logic [CHAN_W-1:0] CHAN_RESET = 2'd2;
  localparam logic [CHAN_W-1:0] CHAN_MONO  = 2'd1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'd1;

  // remainder unit: one quotient bit per cycle
  localparam int DIV_STEPS = STEP_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // request to the remainder unit
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] dividend;
    logic [STEP_W-1:0] divisor;
  } rem_req_t;

endpackage

// ----- src/lir_lerp.sv -----
// Shared interpolation unit: registered multiply, then round toward zero.
`timescale 1ns / 1ps
module lir_lerp (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [lir_pkg::SAMPLE_W-1:0] s0_i,
  input  logic signed [lir_pkg::SAMPLE_W-1:0] s1_i,
  input  logic        [lir_pkg::PHASE_W-1:0]  frac_i,
  output logic signed [lir_pkg::SAMPLE_W-1:0] result_o
);
  import lir_pkg::*;

  logic signed [SAMPLE_W:0]   diff;
  logic signed [PHASE_W:0]    frac_s;
  logic signed [33:0]         prod_d, prod_q;
  logic signed [SAMPLE_W-1:0] base_q;
  logic signed [33:0]         base_ext;
  logic signed [33:0]         sum;
  logic signed [33:0]         sum_rnd;

  // stage 1: difference times fraction
  assign diff   = (SAMPLE_W+1)'(s1_i) - (SAMPLE_W+1)'(s0_i);
  assign frac_s = signed'({1'b0, frac_i});
  assign prod_d = diff * frac_s;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      base_q <= s0_i;
    end
  end

  // stage 2: add the base sample, truncate the Q16 fraction toward zero
  assign base_ext = signed'({{2{base_q[SAMPLE_W-1]}}, base_q, 16'b0});
  assign sum      = base_ext + prod_q;
  assign sum_rnd  = sum[33] ? (sum + 34'sd65535) : sum;
  assign result_o = sum_rnd[31:16];

endmodule

// ----- src/lir_rem.sv -----
// Iterative remainder unit used to rebase the phase after dropped outputs.
`timescale 1ns / 1ps
module lir_rem (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lir_pkg::rem_req_t                req_i,
  output logic                             done_o,
  output logic [lir_pkg::PHASE_W-1:0]      phase_o
);
  import lir_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [STEP_W-1:0]    rem_q, rem_d;
  logic [STEP_W-1:0]    dvd_q, dvd_d;
  logic [STEP_W-1:0]    dsr_q, dsr_d;
  logic [STEP_W:0]      trial;
  logic [STEP_W:0]      trial_sub;
  logic [STEP_W-1:0]    back;

  // one restoring step: shift in a dividend bit, subtract if it fits
  assign trial     = {rem_q, dvd_q[STEP_W-1]};
  assign trial_sub = trial - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_STEPS - 1);
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = (trial >= {1'b0, dsr_q}) ? trial_sub[STEP_W-1:0] : trial[STEP_W-1:0];
      dvd_d = {dvd_q[STEP_W-2:0], 1'b0};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
  end

  // rebased phase is (-d) mod step
  assign back    = dsr_q - rem_q;
  assign done_o  = done_q;
  assign phase_o = (rem_q == '0) ? '0 : back[PHASE_W-1:0];

endmodule

// ----- src/linear_interp_audio_resampler.sv -----
// Linear-interpolation sample-rate converter to 48 kHz: sequencer and top level.
//
//  port group | direction | handshake            | payload
//  cfg        | in        | cfg_we_i             | cfg_index_i, cfg_data_i
//  in         | in        | in_valid_i/in_ready_o| left_sample_i, right_sample_i, packet_last_i
//  out        | out       | out_valid_o/out_ready_i | left_out_o, right_out_o, frame_end_o,
//             |           |                      | run_last_o
//
// An item that causes no output is taken in idle. Otherwise each interval passes S_CHK and
// each output S_MUL_L, S_MUL_R and S_EMIT, the shared multiplier computing left then right
// each output. A capped interval also passes S_DIV, S_DIV_WAIT for the phase remainder unit.
// Reset (async, active low) clears state, phase, frame count and restores the registers.
// A stalled output holds the sequencer in its emit step; input ready is high only when idle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module linear_interp_audio_resampler #(
  parameter int FRAME_SAMPLES         = 960,
  parameter int MAX_OUTPUTS_PER_INPUT = 13
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic        [lir_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [lir_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [lir_pkg::SAMPLE_W-1:0]  left_sample_i,
  input  logic signed [lir_pkg::SAMPLE_W-1:0]  right_sample_i,
  input  logic                                 packet_last_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [lir_pkg::SAMPLE_W-1:0]  left_out_o,
  output logic signed [lir_pkg::SAMPLE_W-1:0]  right_out_o,
  output logic                                 frame_end_o,
  output logic                                 run_last_o
);
  import lir_pkg::*;

  localparam int FW = $clog2(FRAME_SAMPLES + 1);
  localparam int NW = $clog2(MAX_OUTPUTS_PER_INPUT + 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_CHK      = 3'd1;
  localparam logic [2:0] S_MUL_L    = 3'd2;
  localparam logic [2:0] S_MUL_R    = 3'd3;
  localparam logic [2:0] S_EMIT     = 3'd4;
  localparam logic [2:0] S_DIV      = 3'd5;
  localparam logic [2:0] S_DIV_WAIT = 3'd6;

  // configuration
  logic [STEP_W-1:0] step_q, step_eff;
  logic [CHAN_W-1:0] chan_q;
  logic              mono;

  // control state
  logic [2:0]         state_q, state_d;
  logic               have_prev_q, have_prev_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [FW-1:0]      fc_q, fc_d;
  logic [NW-1:0]      n_q, n_d, n_inc;
  logic               hold_next_q, hold_next_d;
  logic               out_valid_q, out_valid_d;

  // payload
  logic signed [SAMPLE_W-1:0] prev_l_q, prev_l_d, prev_r_q, prev_r_d;
  logic signed [SAMPLE_W-1:0] s0l_q, s0l_d, s0r_q, s0r_d, s1l_q, s1l_d, s1r_q, s1r_d;
  logic signed [SAMPLE_W-1:0] res_l_q, res_l_d;
  logic signed [SAMPLE_W-1:0] left_out_q, left_out_d, right_out_q, right_out_d;
  logic                       frame_end_q, frame_end_d, run_last_q, run_last_d;

  logic signed [SAMPLE_W-1:0] in_r;
  logic [STEP_W-1:0]          sum;
  logic                       end_interval;
  logic                       lerp_en, sel_right;
  logic signed [SAMPLE_W-1:0] lerp_s0, lerp_s1, lerp_res;
  rem_req_t                   rem_req;
  logic                       rem_done;
  logic [PHASE_W-1:0]         rem_phase;

  // effective step: zero acts as 1, above 1.0 saturates
  always_comb begin
    if (step_q == '0) begin
      step_eff = STEP_W'(1);
    end else if (step_q > ONE_Q16) begin
      step_eff = ONE_Q16;
    end else begin
      step_eff = step_q;
    end
  end
  assign mono = (chan_q == CHAN_MONO);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_RESET;
      chan_q <= CHAN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PHASE_STEP:    step_q <= cfg_data_i[STEP_W-1:0];
        REG_CHANNEL_COUNT: chan_q <= cfg_data_i[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // shared interpolation unit, left then right
  assign sel_right = (state_q == S_MUL_R);
  assign lerp_s0   = sel_right ? s0r_q : s0l_q;
  assign lerp_s1   = sel_right ? s1r_q : s1l_q;

  lir_lerp u_lerp (
    .clk_i    (clk_i),
    .en_i     (lerp_en),
    .s0_i     (lerp_s0),
    .s1_i     (lerp_s1),
    .frac_i   (phase_q),
    .result_o (lerp_res)
  );

  // remainder unit for the phase rebase after dropped outputs
  always_comb begin
    rem_req.start    = (state_q == S_DIV);
    rem_req.dividend = ONE_Q16 - {1'b0, phase_q};
    rem_req.divisor  = step_eff;
  end

  lir_rem u_rem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (rem_req),
    .done_o  (rem_done),
    .phase_o (rem_phase)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_r       = mono ? '0 : right_sample_i;
  assign sum        = {1'b0, phase_q} + step_eff;
  assign n_inc      = n_q + 1'b1;

  // sequencer
  always_comb begin
    state_d      = state_q;
    have_prev_d  = have_prev_q;
    phase_d      = phase_q;
    fc_d         = fc_q;
    n_d          = n_q;
    hold_next_d  = hold_next_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    prev_l_d     = prev_l_q;
    prev_r_d     = prev_r_q;
    s0l_d        = s0l_q;
    s0r_d        = s0r_q;
    s1l_d        = s1l_q;
    s1r_d        = s1r_q;
    res_l_d      = res_l_q;
    left_out_d   = left_out_q;
    right_out_d  = right_out_q;
    frame_end_d  = frame_end_q;
    run_last_d   = run_last_q;
    lerp_en      = 1'b0;
    end_interval = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          prev_l_d    = left_sample_i;
          prev_r_d    = in_r;
          have_prev_d = !packet_last_i;
          n_d         = '0;
          s1l_d       = left_sample_i;
          s1r_d       = in_r;
          if (have_prev_q) begin
            s0l_d       = prev_l_q;
            s0r_d       = prev_r_q;
            hold_next_d = packet_last_i;
            state_d     = S_CHK;
          end else if (packet_last_i) begin
            // lone last sample: only the hold interval
            s0l_d       = left_sample_i;
            s0r_d       = in_r;
            hold_next_d = 1'b0;
            state_d     = S_CHK;
          end
        end
      end
      S_CHK: begin
        state_d = (n_q == NW'(MAX_OUTPUTS_PER_INPUT)) ? S_DIV : S_MUL_L;
      end
      S_MUL_L: begin
        lerp_en = 1'b1;
        state_d = S_MUL_R;
      end
      S_MUL_R: begin
        lerp_en = 1'b1;
        res_l_d = lerp_res;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          left_out_d  = res_l_q;
          right_out_d = mono ? '0 : lerp_res;
          if (fc_q == FW'(FRAME_SAMPLES - 1)) begin
            fc_d        = '0;
            frame_end_d = 1'b1;
          end else begin
            fc_d        = fc_q + 1'b1;
            frame_end_d = 1'b0;
          end
          run_last_d = (n_inc == NW'(MAX_OUTPUTS_PER_INPUT)) ||
                       (sum[STEP_W-1] && !hold_next_q);
          n_d        = n_inc;
          phase_d    = sum[PHASE_W-1:0];
          if (sum[STEP_W-1]) begin
            end_interval = 1'b1;
          end else if (n_inc == NW'(MAX_OUTPUTS_PER_INPUT)) begin
            state_d = S_DIV;
          end else begin
            state_d = S_MUL_L;
          end
        end
      end
      S_DIV: begin
        state_d = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (rem_done) begin
          phase_d      = rem_phase;
          end_interval = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // interval closed: on to the hold interval or back to idle
    if (end_interval) begin
      if (hold_next_q) begin
        s0l_d       = s1l_q;
        s0r_d       = s1r_q;
        hold_next_d = 1'b0;
        state_d     = S_CHK;
      end else begin
        state_d = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      have_prev_q <= 1'b0;
      phase_q     <= '0;
      fc_q        <= '0;
      n_q         <= '0;
      hold_next_q <= 1'b0;
      out_valid_q <= 1'b0;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
    end else begin
      state_q     <= state_d;
      have_prev_q <= have_prev_d;
      phase_q     <= phase_d;
      fc_q        <= fc_d;
      n_q         <= n_d;
      hold_next_q <= hold_next_d;
      out_valid_q <= out_valid_d;
      prev_l_q    <= prev_l_d;
      prev_r_q    <= prev_r_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s0l_q       <= s0l_d;
    s0r_q       <= s0r_d;
    s1l_q       <= s1l_d;
    s1r_q       <= s1r_d;
    res_l_q     <= res_l_d;
    left_out_q  <= left_out_d;
    right_out_q <= right_out_d;
    frame_end_q <= frame_end_d;
    run_last_q  <= run_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign left_out_o  = left_out_q;
  assign right_out_o = right_out_q;
  assign frame_end_o = frame_end_q;
  assign run_last_o  = run_last_q;

  // checks
  `LIR_ASSERT_ALWAYS(a_n_bound, n_q <= NW'(MAX_OUTPUTS_PER_INPUT), "output count over limit")
  `LIR_ASSERT_IMPL(a_frame_wrap, out_valid_q && frame_end_q, fc_q == '0, "frame count not wrapped")
  `LIR_ASSERT_IMPL(a_rem_state, rem_done, state_q == S_DIV_WAIT, "remainder done out of sequence")

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the linear-interpolation audio resampler.
`timescale 1ns / 1ps
module tb;
  import lir_pkg::*;

  localparam int FRAME_LEN    = 960;
  localparam int MAX_OUTS     = 13;
  // covers the remainder pass after a capped interval, with margin
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 300;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 40;
  localparam int TYPED_PRED   = -1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic                       frame_end;
    logic                       run_last;
  } pcm_out_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  // one directed row: a register write or an item, with up to two typed outputs
  typedef struct packed {
    row_kind_e                  kind;
    logic [CFG_IDX_W-1:0]       idx;
    logic [CFG_W-1:0]           val;
    logic signed [SAMPLE_W-1:0] l;
    logic signed [SAMPLE_W-1:0] r;
    logic                       last;
    int                         n_typed;
    logic signed [SAMPLE_W-1:0] t0l;
    logic signed [SAMPLE_W-1:0] t0r;
    logic signed [SAMPLE_W-1:0] t1l;
    logic signed [SAMPLE_W-1:0] t1r;
  } stim_row_t;

  // unit and saturated steps pass samples through, so those outputs are typed in
  stim_row_t dir_rows [0:32] = '{
    '{ROW_CFG,  REG_PHASE_STEP,    ONE_Q16,         '0, '0, 1'b0, 0, '0, '0, '0, '0},
    '{ROW_ITEM, 1'b0, '0, 16'h7FFF, 16'h8000, 1'b0, 0, '0, '0, '0, '0},
    '{ROW_ITEM, 1'b0, '0, 16'h8000, 16'h7FFF, 1'b0, 1, 16'h7FFF, 16'h8000, '0, '0},
    '{ROW_ITEM, 1'b0, '0, '0, '0, 1'b1, 2, 16'h8000, 16'h7FFF, '0, '0},
    '{ROW_ITEM, 1'b0, '0, 16'sd1234, -16'sd1, 1'b1, 1, 16'sd1234, -16'sd1, '0, '0},
    '{ROW_CFG,  REG_CHANNEL_COUNT, 17'(CHAN_MONO),  '0, '0, 1'b0, 0, '0, '0, '0, '0},
    '{ROW_ITEM, 1'b0, '0, 16'sd100, 16'sd555, 1'b0, 0, '0, '0, '0, '0},
    '{ROW_ITEM, 1'b0, '0, -16'sd7, 16'sd999, 1'b1, 2, 16'sd100, '0, -16'sd7, '0},
    '{ROW_CFG,  REG_CHANNEL_COUNT, 17'd0,           '0, '0, 1'b0, 0, '0, '0, '0, '0},
    '{ROW_ITEM, 1'b0, '0, 16'sd5, 16'sd6, 1'b0, 0, '0, '0, '0, '0},
    '{ROW_ITEM, 1'b0, '0, 16'sd7, 16'sd8, 1'b1, 2, 16'sd5, 16'sd6, 16'sd7, 16'sd8},
    '{ROW_CFG,  REG_CHANNEL_COUNT, 17'd3,           '0, '0, 1'b0, 0, '0, '0, '0, '0},
    '{ROW_ITEM, 1'b0, '0, 16'h7FFF, 16'h7FFF, 1'b0, 0, '0, '0, '0, '0},
    '{ROW_ITEM, 1'b0, '0, 16'h8000, 16'h8000, 1'b1, 2, 16'h7FFF, 16'h7FFF,
      16'h8000, 16'h8000},
    '{ROW_CFG,  REG_PHASE_STEP,    17'h1FFFF,       '0, '0, 1'b0, 0, '0, '0, '0, '0},
    '{ROW_ITEM, 1'b0, '0, 16'sd11, 16'sd22, 1'b0, 0, '0, '0, '0, '0},
    '{ROW_ITEM, 1'b0, '0, 16'sd33, 16'sd44, 1'b1, 2, 16'sd11, 16'sd22, 16'sd33, 16'sd44},
    '{ROW_CFG,  REG_PHASE_STEP,    17'd0,           '0, '0, 1'b0, 0, '0, '0, '0, '0},
    '{ROW_ITEM, 1'b0, '0, 16'h7FFF, 16'h8000, 1'b0, 0, '0, '0, '0, '0},
    '{ROW_ITEM, 1'b0, '0, 16'h8000, 16'h7FFF, 1'b1, TYPED_PRED, '0, '0, '0, '0},
    '{ROW_CFG,  REG_PHASE_STEP,    17'd5000,        '0, '0, 1'b0, 0, '0, '0, '0, '0},
    '{ROW_ITEM, 1'b0, '0, 16'sd1000, -16'sd1000, 1'b0, 0, '0, '0, '0, '0},
    '{ROW_ITEM, 1'b0, '0, -16'sd20000, 16'sd30000, 1'b0, TYPED_PRED, '0, '0, '0, '0},
    '{ROW_ITEM, 1'b0, '0, 16'h7FFF, 16'h8000, 1'b1, TYPED_PRED, '0, '0, '0, '0},
    '{ROW_CFG,  REG_PHASE_STEP,    STEP_RESET,      '0, '0, 1'b0, 0, '0, '0, '0, '0},
    '{ROW_CFG,  REG_CHANNEL_COUNT, 17'(CHAN_RESET), '0, '0, 1'b0, 0, '0, '0, '0, '0},
    '{ROW_ITEM, 1'b0, '0, 16'sd500, 16'sd600, 1'b0, 0, '0, '0, '0, '0},
    '{ROW_CFG,  REG_PHASE_STEP,    17'd30000,       '0, '0, 1'b0, 0, '0, '0, '0, '0},
    '{ROW_ITEM, 1'b0, '0, -16'sd500, -16'sd600, 1'b1, TYPED_PRED, '0, '0, '0, '0},
    '{ROW_CFG,  REG_PHASE_STEP,    17'd1,           '0, '0, 1'b0, 0, '0, '0, '0, '0},
    '{ROW_ITEM, 1'b0, '0, 16'sd1, 16'sd2, 1'b1, TYPED_PRED, '0, '0, '0, '0},
    '{ROW_ITEM, 1'b0, '0, -16'sd1, -16'sd2, 1'b0, 0, '0, '0, '0, '0},
    '{ROW_ITEM, 1'b0, '0, 16'sd2, 16'sd3, 1'b1, TYPED_PRED, '0, '0, '0, '0}
  };

  // DUT ports
  logic                        clk_i          = 1'b0;
  logic                        rst_ni         = 1'b0;
  logic                        cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index_i    = '0;
  logic [CFG_W-1:0]            cfg_data_i     = '0;
  logic                        in_valid_i     = 1'b0;
  logic                        in_ready_o;
  logic signed [SAMPLE_W-1:0]  left_sample_i  = '0;
  logic signed [SAMPLE_W-1:0]  right_sample_i = '0;
  logic                        packet_last_i  = 1'b0;
  logic                        out_valid_o;
  logic                        out_ready_i    = 1'b0;
  logic signed [SAMPLE_W-1:0]  left_out_o;
  logic signed [SAMPLE_W-1:0]  right_out_o;
  logic                        frame_end_o;
  logic                        run_last_o;

  // predictor copy of registers and state
  logic [STEP_W-1:0]           step_reg   = STEP_RESET;
  logic [CHAN_W-1:0]           chan_reg   = CHAN_RESET;
  logic signed [SAMPLE_W-1:0]  held_left  = '0;
  logic signed [SAMPLE_W-1:0]  held_right = '0;
  bit                          held_valid = 1'b0;
  int unsigned                 acc_phase  = 0;
  int unsigned                 frame_pos  = 0;

  pcm_out_t interp_outs[$];
  pcm_out_t expected_pcm[$];

  int mismatches  = 0;
  int items_sent  = 0;
  int outs_seen   = 0;
  int frame_marks = 0;
  int cfg_writes  = 0;
  int out_wait    = 0;
  bit long_hold   = 1'b0;
  bit rand_started = 1'b0;
  bit in_burst    = 1'b0;
  bit out_burst   = 1'b0;

  linear_interp_audio_resampler #(
    .FRAME_SAMPLES         (FRAME_LEN),
    .MAX_OUTPUTS_PER_INPUT (MAX_OUTS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .packet_last_i  (packet_last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .left_out_o     (left_out_o),
    .right_out_o    (right_out_o),
    .frame_end_o    (frame_end_o),
    .run_last_o     (run_last_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // s0 + frac * (s1 - s0), truncated toward zero
  function automatic logic signed [SAMPLE_W-1:0] lerp16(input logic signed [SAMPLE_W-1:0] s0,
                                                       input logic signed [SAMPLE_W-1:0] s1,
                                                       input int unsigned frac);
    longint acc;
    acc = longint'(s0) * 65536 + longint'(frac) * (longint'(s1) - longint'(s0));
    return SAMPLE_W'(acc / 65536);
  endfunction

  // emit the output positions inside one input interval, up to the output limit, then rebase the phase
  task automatic walk_interval(input logic signed [SAMPLE_W-1:0] l0, r0, l1, r1,
                               input bit hold);
    int unsigned one;
    int unsigned step;
    int unsigned skip;
    bit          mono;
    pcm_out_t    o;
    one  = ONE_Q16;
    step = (step_reg == 0) ? 1 : ((step_reg > ONE_Q16) ? one : step_reg);
    mono = (chan_reg == CHAN_MONO);
    while (acc_phase < one && interp_outs.size() < MAX_OUTS) begin
      o.left  = hold ? l0 : lerp16(l0, l1, acc_phase & 32'hFFFF);
      o.right = mono ? '0 : (hold ? r0 : lerp16(r0, r1, acc_phase & 32'hFFFF));
      frame_pos++;
      o.frame_end = (frame_pos >= FRAME_LEN);
      if (o.frame_end) frame_pos = 0;
      o.run_last = 1'b0;
      interp_outs.push_back(o);
      acc_phase += step;
    end
    // dropped positions still advance the phase
    if (acc_phase < one) begin
      skip = (one - acc_phase + step - 1) / step;
      acc_phase += skip * step;
    end
    acc_phase -= one;
  endtask

  // outputs caused by one input item, left in interp_outs
  task automatic resample_item(input logic signed [SAMPLE_W-1:0] l, r, input bit last);
    logic signed [SAMPLE_W-1:0] rr;
    pcm_out_t                   o;
    interp_outs.delete();
    rr = (chan_reg == CHAN_MONO) ? '0 : r;
    if (held_valid) walk_interval(held_left, held_right, l, rr, 1'b0);
    held_left  = l;
    held_right = rr;
    held_valid = 1'b1;
    if (last) begin
      walk_interval(l, rr, l, rr, 1'b1);
      held_valid = 1'b0;
    end
    if (interp_outs.size() > 0) begin
      o = interp_outs.pop_back();
      o.run_last = 1'b1;
      interp_outs.push_back(o);
    end
  endtask

  // idle cycles before the next item on either side; bursts run with no gaps
  function automatic int draw_gap(inout bit burst);
    if ($urandom_range(0, 31) == 0) burst = !burst;
    return burst ? 0 : int'($urandom_range(0, 4));
  endfunction

  // offer one item, wait for it to be taken, predict its outputs
  task automatic send_item(input logic signed [SAMPLE_W-1:0] l, r, input bit last,
                           input bit use_pred);
    int gap;
    gap = draw_gap(in_burst);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    left_sample_i  <= l;
    right_sample_i <= r;
    packet_last_i  <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    resample_item(l, r, last);
    if (use_pred) foreach (interp_outs[i]) expected_pcm.push_back(interp_outs[i]);
  endtask

  // wait until every expected output is out and the block has gone quiet
  task automatic settle_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_pcm.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    settle_idle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_PHASE_STEP) step_reg = val[STEP_W-1:0];
    else chan_reg = val[CHAN_W-1:0];
    cfg_writes++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  // compare one taken output with the oldest expectation
  task automatic check_output();
    pcm_out_t got;
    pcm_out_t want;
    got = {left_out_o, right_out_o, frame_end_o, run_last_o};
    outs_seen++;
    if (got.frame_end === 1'b1) frame_marks++;
    if (expected_pcm.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected output L=%0d R=%0d fe=%0b rl=%0b",
                 got.left, got.right, got.frame_end, got.run_last);
    end else begin
      want = expected_pcm.pop_front();
      if (got.left !== want.left || got.right !== want.right ||
          got.frame_end !== want.frame_end || got.run_last !== want.run_last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("output %0d: expected L=%0d R=%0d fe=%0b rl=%0b, got L=%0d R=%0d fe=%0b rl=%0b",
                   outs_seen, want.left, want.right, want.frame_end, want.run_last,
                   got.left, got.right, got.frame_end, got.run_last);
      end
    end
  endtask

  // output side: ready driven at falling edges, items taken at rising edges
  initial begin
    forever begin
      @(negedge clk_i);
      if (long_hold) begin
        out_ready_i <= 1'b0;
      end else if (out_wait > 0) begin
        out_ready_i <= 1'b0;
        out_wait--;
      end else begin
        out_ready_i <= 1'b1;
      end
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        check_output();
        out_wait = draw_gap(out_burst);
      end
    end
  end

  // one long output stall early in the random part so the input backs up
  initial begin
    wait (rand_started);
    repeat (40) @(posedge clk_i);
    long_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    long_hold = 1'b0;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // stimulus
  initial begin
    pcm_out_t          typed_o;
    logic [STEP_W-1:0] step_sel;
    logic [CHAN_W-1:0] chan_sel;
    int                pkt_left;
    logic [STEP_W-1:0] phase_steps [RAND_PHASES] = '{
      STEP_RESET, 17'd4800, 17'd0, 17'd2000, 17'd21845, 17'd1, 17'd10923, ONE_Q16
    };

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_item(dir_rows[i].l, dir_rows[i].r, dir_rows[i].last,
                  dir_rows[i].n_typed == TYPED_PRED);
        for (int k = 0; k < dir_rows[i].n_typed; k++) begin
          typed_o.left      = (k == 0) ? dir_rows[i].t0l : dir_rows[i].t1l;
          typed_o.right     = (k == 0) ? dir_rows[i].t0r : dir_rows[i].t1r;
          typed_o.frame_end = 1'b0;
          typed_o.run_last  = (k == dir_rows[i].n_typed - 1);
          expected_pcm.push_back(typed_o);
        end
      end
    end

    // random packets under several register settings
    rand_started = 1'b1;
    pkt_left = 0;
    for (int p = 0; p < RAND_PHASES; p++) begin
      step_sel = (phase_steps[p] == 0) ? STEP_W'($urandom_range(1, 65536)) : phase_steps[p];
      chan_sel = CHAN_W'($urandom_range(0, 3));
      write_reg(REG_PHASE_STEP, step_sel);
      // upper data bits are don't-care for the channel register
      write_reg(REG_CHANNEL_COUNT, {CFG_W'($urandom()) >> CHAN_W << CHAN_W} | chan_sel);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (pkt_left == 0)
          pkt_left = ($urandom_range(0, 7) == 0) ? 1 : int'($urandom_range(2, 12));
        send_item(rand_sample(), rand_sample(), pkt_left == 1, 1'b1);
        pkt_left--;
      end
    end

    settle_idle();
    $display("covered %0d items, %0d outputs, %0d frame ends, %0d register writes",
             items_sent, outs_seen, frame_marks, cfg_writes);
    $display("steps from 0 to saturation, mono and stereo, one %0d-cycle output stall",
             HOLD_CYCLES);
    if (mismatches == 0 && expected_pcm.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
